@@ sv/percent_escape_decoder_top_defines.svh @@
// ----------------------------------------------------------------------------
// Percent-escape decoder assertion macros
// Concurrent assertion wrappers; empty bodies when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef PERCENT_ESCAPE_DECODER_TOP_DEFINES_SVH
`define PERCENT_ESCAPE_DECODER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define PCTD_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pctd: immediate implication violated");
`define PCTD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pctd: next-cycle implication violated");
`else
`define PCTD_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define PCTD_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

@@ sv/pctd_pkg.sv @@
// ----------------------------------------------------------------------------
// Percent-escape decoder package
// Beat types, queue entry type, escape phase encoding and hex helpers.
// ----------------------------------------------------------------------------
package pctd_pkg;

   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_0       = 8'h30;
   localparam logic [7:0] CH_9       = 8'h39;
   localparam logic [7:0] CH_LA      = 8'h61;
   localparam logic [7:0] CH_LF      = 8'h66;
   localparam logic [7:0] CH_UA      = 8'h41;
   localparam logic [7:0] CH_UF      = 8'h46;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
   } rsp_type;

   // up to three output bytes produced by one input beat; data[0] goes first
   typedef struct packed {
      logic [2:0][7:0] data;
      logic [1:0]      count;
      logic            last;
   } cmd_type;

   typedef enum logic [2:0] {
      PH_IDLE = 3'b001,
      PH_PCT  = 3'b010,
      PH_HIGH = 3'b100
   } phase_type;

   function automatic logic is_hex(input logic [7:0] c);
      return ((c >= CH_0) && (c <= CH_9)) ||
             ((c >= CH_LA) && (c <= CH_LF)) ||
             ((c >= CH_UA) && (c <= CH_UF));
   endfunction

   // valid only for hex digits: letters have low nibble 1..6
   function automatic logic [3:0] hex_nibble(input logic [7:0] c);
      return (c <= CH_9) ? c[3:0] : c[3:0] + 4'd9;
   endfunction

endpackage

@@ sv/pctd_front.sv @@
// ----------------------------------------------------------------------------
// Percent-escape decoder front end
// Tracks escape phase and turns each accepted beat that yields output bytes into a queue entry.
// ----------------------------------------------------------------------------
module pctd_front import pctd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    accept,
   input  req_type req_data,
   output cmd_type cmd,
   output logic    cmd_valid,
   output logic    idle
);

   phase_type  phase_ff, phase_in;
   logic [7:0] held_ff, held_in;
   logic [1:0] cnt;
   logic       fresh;
   logic [7:0] b;
   logic       b_hex;

   assign b     = req_data.in_byte;
   assign b_hex = is_hex(b);

   always_comb begin
      phase_in = phase_ff;
      held_in  = held_ff;
      cmd      = '0;
      cnt      = 2'd0;
      fresh    = 1'b0;
      unique case (phase_ff)
         PH_IDLE: begin
            fresh = 1'b1;
         end
         PH_PCT: begin
            if (b_hex) begin
               held_in  = b;
               phase_in = PH_HIGH;
            end else begin
               cmd.data[cnt] = CH_PERCENT;
               cnt           = cnt + 2'd1;
               fresh         = 1'b1;
            end
         end
         PH_HIGH: begin
            if (b_hex) begin
               cmd.data[cnt] = {hex_nibble(held_ff), hex_nibble(b)};
               cnt           = cnt + 2'd1;
               phase_in      = PH_IDLE;
            end else begin
               cmd.data[cnt] = CH_PERCENT;
               cnt           = cnt + 2'd1;
               cmd.data[cnt] = held_ff;
               cnt           = cnt + 2'd1;
               fresh         = 1'b1;
            end
         end
         default: begin
            fresh = 1'b1;
         end
      endcase
      if (fresh) begin
         if (b == CH_PERCENT) begin
            phase_in = PH_PCT;
         end else begin
            cmd.data[cnt] = b;
            cnt           = cnt + 2'd1;
            phase_in      = PH_IDLE;
         end
      end
      if (req_data.in_last) begin
         if (phase_in == PH_PCT) begin
            cmd.data[cnt] = CH_PERCENT;
            cnt           = cnt + 2'd1;
         end else if (phase_in == PH_HIGH) begin
            cmd.data[cnt] = CH_PERCENT;
            cnt           = cnt + 2'd1;
            cmd.data[cnt] = held_in;
            cnt           = cnt + 2'd1;
         end
         phase_in = PH_IDLE;
         held_in  = 8'd0;
      end
      cmd.count = cnt;
      cmd.last  = req_data.in_last;
   end

   assign cmd_valid = accept && (cnt != 2'd0);
   assign idle      = (phase_ff == PH_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         held_ff  <= 8'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
      end
   end

endmodule

@@ sv/pctd_fifo.sv @@
// ----------------------------------------------------------------------------
// Percent-escape decoder entry queue
// Small register queue between front end and serializer.
// ----------------------------------------------------------------------------
module pctd_fifo import pctd_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type wr_data,
   input  logic    pop,
   output cmd_type rd_data,
   output logic    full,
   output logic    empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   cnt_ff;

   assign full    = (cnt_ff == CNT_W'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign rd_data = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

endmodule

@@ sv/pctd_back.sv @@
// ----------------------------------------------------------------------------
// Percent-escape decoder back end
// Serializes queue entries into single-byte result beats via an output register.
// ----------------------------------------------------------------------------
module pctd_back import pctd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    fifo_empty,
   input  cmd_type fifo_data,
   output logic    fifo_pop,
   input  logic    rsp_pop,
   output logic    rsp_empty,
   output rsp_type rsp_data
);

   cmd_type    cmd_ff, cmd_in;
   logic       cmd_valid_ff, cmd_valid_in;
   logic [1:0] idx_ff, idx_in;
   rsp_type    out_ff, out_in;
   logic       out_valid_ff, out_valid_in;
   logic       out_free, emit, at_end, cmd_done;

   assign out_free = !out_valid_ff || rsp_pop;
   assign emit     = cmd_valid_ff && out_free;
   assign at_end   = (idx_ff == (cmd_ff.count - 2'd1));
   assign cmd_done = emit && at_end;
   assign fifo_pop = !fifo_empty && (!cmd_valid_ff || cmd_done);

   always_comb begin
      cmd_in       = cmd_ff;
      cmd_valid_in = cmd_valid_ff;
      idx_in       = idx_ff;
      if (fifo_pop) begin
         cmd_in       = fifo_data;
         cmd_valid_in = 1'b1;
         idx_in       = 2'd0;
      end else if (cmd_done) begin
         cmd_valid_in = 1'b0;
      end else if (emit) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_comb begin
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (emit) begin
         out_in.out_byte = cmd_ff.data[idx_ff];
         out_in.out_last = cmd_ff.last && at_end;
         out_valid_in    = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      idx_ff <= idx_in;
      out_ff <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cmd_valid_ff <= cmd_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

@@ sv/percent_escape_decoder_top.sv @@
// ----------------------------------------------------------------------------
// Percent-escape decoder top level
// Decodes %XY escapes of a byte stream; malformed escapes pass through.
// ----------------------------------------------------------------------------
// Input side is a queue write port: drive req_data and raise req_push; the
// beat is taken on a clock edge with req_push high and req_full low. Mark
// the final byte of a string with in_last.
// Output side is a queue read port: while rsp_empty is low the oldest byte
// sits on rsp_data; raising rsp_pop takes it. out_last marks a string's end.
// One input beat yields zero to three result bytes. The front end takes a
// beat every cycle while its entry queue (QUEUE_DEPTH entries) has room;
// the serializer emits one result byte per cycle while the reader pops, so
// sustained throughput is one byte per cycle. The first result byte of a beat
// passes through the queue, the entry register and the output register.
// A stalled reader fills the output register, the entry register, then the
// queue, then raises req_full; nothing is dropped. Synchronous reset empties
// the queue and output register and clears any pending escape.
// ----------------------------------------------------------------------------
`include "percent_escape_decoder_top_defines.svh"

module percent_escape_decoder_top import pctd_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_data,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   logic    accept;
   cmd_type front_cmd, fifo_cmd;
   logic    front_valid, front_idle;
   logic    fifo_full, fifo_empty, fifo_pop;

   assign req_full = fifo_full;
   assign accept   = req_push && !fifo_full;

   pctd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_data  (req_data),
      .cmd       (front_cmd),
      .cmd_valid (front_valid),
      .idle      (front_idle)
   );

   pctd_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (front_valid),
      .wr_data (front_cmd),
      .pop     (fifo_pop),
      .rd_data (fifo_cmd),
      .full    (fifo_full),
      .empty   (fifo_empty)
   );

   pctd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .fifo_empty (fifo_empty),
      .fifo_data  (fifo_cmd),
      .fifo_pop   (fifo_pop),
      .rsp_pop    (rsp_pop),
      .rsp_empty  (rsp_empty),
      .rsp_data   (rsp_data)
   );

   `PCTD_ASSERT_IMPLY(a_push_not_full, clock, reset, front_valid, !fifo_full)
   `PCTD_ASSERT_IMPLY(a_entry_nonempty, clock, reset, front_valid, front_cmd.count != 2'd0)
   `PCTD_ASSERT_NEXT(a_last_clears_phase, clock, reset, accept && req_data.in_last, front_idle)
   `PCTD_ASSERT_IMPLY(a_last_has_output, clock, reset, accept && req_data.in_last, front_valid)

endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// Percent-escape decoder testbench
// Streams directed and random strings into the decoder through its queue
// ports, predicts every output byte with a local decoder model and checks
// each popped byte against the oldest prediction, under varying idle rates.
// ----------------------------------------------------------------------------
module tb_top;
   import pctd_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 20;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_push = 1'b0;
   logic    req_full;
   req_type req_data = '0;
   logic    rsp_empty;
   logic    rsp_pop = 1'b0;
   rsp_type rsp_data;

   req_type   byte_q[$];
   rsp_type   decoded_q[$];
   phase_type esc_phase = PH_IDLE;
   logic [7:0] held_digit = 8'h00;
   int        send_idle_pct = 10;
   int        recv_idle_pct = 75;
   int        error_count = 0;
   int        cycle_count = 0;
   string     hex_chars = "0123456789abcdefABCDEF";

   percent_escape_decoder_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch @%0t: %s", $time, msg);
      error_count++;
   endtask

   // bit 4 set when c is a hex digit, bits 3:0 its value
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [7:0] v;
      if (c >= CH_0 && c <= CH_9) begin
         v = c - CH_0;
         return {1'b1, v[3:0]};
      end
      if (c >= CH_LA && c <= CH_LF) begin
         v = c - CH_LA + 8'd10;
         return {1'b1, v[3:0]};
      end
      if (c >= CH_UA && c <= CH_UF) begin
         v = c - CH_UA + 8'd10;
         return {1'b1, v[3:0]};
      end
      return 5'b0;
   endfunction

   // no escape pending: open one on '%', otherwise pass the byte
   task automatic scan_plain(input logic [7:0] b, ref logic [7:0] outs[$]);
      if (b == CH_PERCENT) begin
         esc_phase = PH_PCT;
      end else begin
         esc_phase = PH_IDLE;
         outs.push_back(b);
      end
   endtask

   task automatic decode_beat(input req_type beat);
      logic [7:0] outs[$];
      logic [4:0] lo;
      logic [4:0] hi;
      rsp_type    r;
      int         n;
      case (esc_phase)
         PH_PCT: begin
            lo = hex_digit(beat.in_byte);
            if (lo[4]) begin
               held_digit = beat.in_byte;
               esc_phase = PH_HIGH;
            end else begin
               outs.push_back(CH_PERCENT);
               scan_plain(beat.in_byte, outs);
            end
         end
         PH_HIGH: begin
            lo = hex_digit(beat.in_byte);
            hi = hex_digit(held_digit);
            if (lo[4] && hi[4]) begin
               outs.push_back({hi[3:0], lo[3:0]});
               esc_phase = PH_IDLE;
            end else begin
               outs.push_back(CH_PERCENT);
               outs.push_back(held_digit);
               scan_plain(beat.in_byte, outs);
            end
         end
         default: begin
            scan_plain(beat.in_byte, outs);
         end
      endcase
      if (beat.in_last) begin
         if (esc_phase == PH_PCT) begin
            outs.push_back(CH_PERCENT);
         end else if (esc_phase == PH_HIGH) begin
            outs.push_back(CH_PERCENT);
            outs.push_back(held_digit);
         end
         esc_phase = PH_IDLE;
         held_digit = 8'h00;
      end
      n = (outs.size() > 3) ? 3 : outs.size();
      for (int k = 0; k < n; k++) begin
         r.out_byte = outs[k];
         r.out_last = beat.in_last && (k == n - 1);
         decoded_q.push_back(r);
      end
   endtask

   function automatic void add_byte(input logic [7:0] b, input logic last);
      req_type t;
      t.in_byte = b;
      t.in_last = last;
      byte_q.push_back(t);
   endfunction

   task automatic add_string(input string s);
      for (int i = 0; i < s.len(); i++) begin
         add_byte(s[i], i == s.len() - 1);
      end
   endtask

   // random string built from tokens; returns number of bytes queued
   function automatic int add_random_string();
      logic [7:0] chars[$];
      int         tokens;
      int         pick;
      tokens = $urandom_range(1, 6);
      for (int t = 0; t < tokens; t++) begin
         pick = $urandom_range(99);
         if (pick < 50) begin
            chars.push_back(CH_PERCENT);
            chars.push_back(hex_chars[$urandom_range(21)]);
            chars.push_back(hex_chars[$urandom_range(21)]);
         end else if (pick < 60) begin
            chars.push_back(CH_PERCENT);
            chars.push_back(hex_chars[$urandom_range(21)]);
            if ($urandom_range(1)) chars.push_back(8'($urandom_range(255)));
         end else if (pick < 70) begin
            chars.push_back(CH_PERCENT);
            if ($urandom_range(1)) chars.push_back(8'($urandom_range(255)));
         end else begin
            chars.push_back(8'($urandom_range(255)));
         end
      end
      foreach (chars[i]) add_byte(chars[i], i == chars.size() - 1);
      return chars.size();
   endfunction

   task automatic add_random_phase(input int target);
      int queued;
      queued = 0;
      while (queued < target) queued += add_random_string();
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (byte_q.size() != 0 || req_push || decoded_q.size() != 0);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) decode_beat(req_data);
         if (req_push && req_full) begin
            req_push <= 1'b1;
         end else if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_data <= byte_q.pop_front();
            req_push <= 1'b1;
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (decoded_q.size() == 0) begin
               report_mismatch($sformatf("unexpected beat byte=%02h last=%0b",
                                         rsp_data.out_byte, rsp_data.out_last));
            end else begin
               if (rsp_data.out_byte !== decoded_q[0].out_byte)
                  report_mismatch($sformatf("out_byte %02h, want %02h",
                                            rsp_data.out_byte, decoded_q[0].out_byte));
               if (rsp_data.out_last !== decoded_q[0].out_last)
                  report_mismatch($sformatf("out_last %0b, want %0b (byte %02h)",
                                            rsp_data.out_last, decoded_q[0].out_last,
                                            decoded_q[0].out_byte));
               void'(decoded_q.pop_front());
            end
         end
         rsp_pop <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed strings
      add_byte(8'h00, 1'b1);
      add_byte(8'hFF, 1'b1);
      add_string("%aF");
      add_string("%9A");
      add_string("%%0f");
      add_string("%G0");
      add_string("%5:");
      add_string("%4%");
      add_string("%");
      add_string("%@7");
      add_string("%/g");
      wait_drained();

      add_random_phase(60);
      wait_drained();

      send_idle_pct = 75;
      recv_idle_pct = 10;
      add_random_phase(60);
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      add_random_phase(60);
      wait_drained();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+sv
sv/pctd_pkg.sv
sv/pctd_front.sv
sv/pctd_fifo.sv
sv/pctd_back.sv
sv/percent_escape_decoder_top.sv
verif/tb_top.sv
